FILE: hdl/bayer_bilinear_demosaic_defines.svh
// Assertion macros for the Bayer demosaic checker.
`ifndef BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH

// Same-cycle implication.
`define BBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define BBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/bbd_pkg.sv
// Shared constants, types and codes of the Bayer demosaic.
package bbd_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int LINES     = 4;
    localparam int QDEPTH    = 4;
    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int WID_W     = 12;
    localparam int HGT_W     = 13;
    localparam int BANK_W    = $clog2(LINES);
    localparam int QCNT_W    = $clog2(QDEPTH) + 1;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int IDX_W     = 2;
    localparam int DATA_W    = 13;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

    typedef enum logic [IDX_W-1:0] {
        CFG_PATTERN = 2'd0,
        CFG_WIDTH   = 2'd1,
        CFG_HEIGHT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CM_NORMAL,
        CM_LEFT,
        CM_RIGHT
    } cmode_t;

    typedef logic [3:0][PIX_W-1:0]      col_t;
    typedef logic [3:0][3:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t          win;
        logic [ROW_W-1:0] y;
        logic [COL_W-1:0] x;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } push_t;

    typedef struct packed {
        logic              nonempty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage

FILE: hdl/bbd_ifs.sv
// Stream and configuration interfaces of the Bayer demosaic.
interface bbd_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [bbd_pkg::PIX_W-1:0] raw_pixel;
    modport source (output valid, output raw_pixel, input ready);
    modport sink   (input valid, input raw_pixel, output ready);
endinterface

interface bbd_rgb_if;
    logic                      valid;
    logic                      ready;
    logic [bbd_pkg::PIX_W-1:0] red;
    logic [bbd_pkg::PIX_W-1:0] green;
    logic [bbd_pkg::PIX_W-1:0] blue;
    logic [bbd_pkg::ROW_W-1:0] pixel_row;
    logic [bbd_pkg::COL_W-1:0] pixel_col;
    logic                      block_last;
    modport source (output valid, output red, output green, output blue,
                    output pixel_row, output pixel_col, output block_last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input pixel_row, input pixel_col, input block_last, output ready);
endinterface

interface bbd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bbd_pkg::IDX_W-1:0]  index;
    logic [bbd_pkg::DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/bayer_bilinear_demosaic.sv
// Top level of the bilinear Bayer demosaic: configuration registers and block wiring.
//
// pix_in carries one raw 8-bit Bayer sample per word in raster order.
// rgb_out carries one RGB pixel per word with its row and column; each 2x2
// block comes out as top left, top right, bottom left, bottom right, and the
// fourth word has block_last set.
// cfg writes pattern (index 0), frame_width (1) and frame_height (2); it is
// always ready and must only be used while no frame data is in flight.
// The sample that completes a block's 4x4 window is registered in stage A,
// then the block enters the queue and its first word the output register.
// Throughput: the output register moves one word a cycle while rgb_out is
// ready, four per block; pix_in takes a sample in every cycle while the
// four-entry block queue has room.
// A stalled rgb_out holds its word; the queue fills and pix_in.ready drops.
// Reset clears the raster counters, the queue and the output register and
// loads pattern RGGB, width 640, height 480. Line stores are not cleared.
module bayer_bilinear_demosaic (
    input  logic       clk,
    input  logic       rst_n,
    bbd_pixel_if.sink  pix_in,
    bbd_rgb_if.source  rgb_out,
    bbd_cfg_if.sink    cfg
);

    logic                       pattern_reg;
    logic [bbd_pkg::WID_W-1:0]  width_reg;
    logic [bbd_pkg::HGT_W-1:0]  height_reg;
    bbd_pkg::push_t             push;
    bbd_pkg::qstat_t            qstat;
    bbd_pkg::qentry_t           head;
    logic                       pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= 1'b0;
            width_reg   <= bbd_pkg::WIDTH_RESET;
            height_reg  <= bbd_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (bbd_pkg::cfg_idx_t'(cfg.index))
                bbd_pkg::CFG_PATTERN: pattern_reg <= cfg.data[0];
                bbd_pkg::CFG_WIDTH:   width_reg   <= cfg.data[bbd_pkg::WID_W-1:0];
                bbd_pkg::CFG_HEIGHT:  height_reg  <= cfg.data[bbd_pkg::HGT_W-1:0];
                default:              ;
            endcase
        end
    end

    bbd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_in),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .qstat        (qstat),
        .push         (push)
    );

    bbd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat),
        .head  (head)
    );

    bbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pattern (pattern_reg),
        .qstat   (qstat),
        .head    (head),
        .pop     (pop),
        .rgb_out (rgb_out)
    );

endmodule

FILE: hdl/bbd_front.sv
// Front end: line stores, raster counters, window assembly and block detection.
module bbd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    bbd_pixel_if.sink                  pix_in,
    input  logic [bbd_pkg::WID_W-1:0]  frame_width,
    input  logic [bbd_pkg::HGT_W-1:0]  frame_height,
    input  bbd_pkg::qstat_t            qstat,
    output bbd_pkg::push_t             push
);

    logic [bbd_pkg::COL_W-1:0] col_reg, col_next;
    logic [bbd_pkg::ROW_W-1:0] row_reg, row_next;

    logic                        a_valid_reg;
    logic                        a_emit_reg, a_emit_next;
    logic [bbd_pkg::PIX_W-1:0]   a_pix_reg;
    logic [bbd_pkg::BANK_W-1:0]  a_bank_reg;
    logic [3:0][1:0]             a_rowk_reg, a_rowk_next;
    bbd_pkg::cmode_t             a_cmode_reg, a_cmode_next;
    logic [bbd_pkg::ROW_W-1:0]   a_y_reg, a_y_next;
    logic [bbd_pkg::COL_W-1:0]   a_x_reg, a_x_next;
    bbd_pkg::col_t               s_reg [3];

    logic [bbd_pkg::PIX_W-1:0]   rd_data [bbd_pkg::LINES];
    logic [bbd_pkg::WID_W-1:0]   w_eff;
    logic [bbd_pkg::HGT_W-1:0]   h_eff;
    logic [bbd_pkg::HGT_W-1:0]   r13;
    logic [bbd_pkg::WID_W-1:0]   c12;
    logic                        y_even, y_bot, x_even, x_right;
    logic                        accept;
    logic [bbd_pkg::QCNT_W:0]    inflight;
    bbd_pkg::col_t               vec;
    bbd_pkg::col_t               cs [4];

    // effective frame size
    always_comb
    begin
        w_eff = {frame_width[bbd_pkg::WID_W-1:1], 1'b0};
        if (w_eff < bbd_pkg::WID_W'(4))
            w_eff = bbd_pkg::WID_W'(4);
        else if (w_eff > bbd_pkg::WID_W'(bbd_pkg::MAX_WIDTH))
            w_eff = bbd_pkg::WID_W'(bbd_pkg::MAX_WIDTH);
        h_eff = {frame_height[bbd_pkg::HGT_W-1:1], 1'b0};
        if (h_eff < bbd_pkg::HGT_W'(4))
            h_eff = bbd_pkg::HGT_W'(4);
        else if (h_eff > bbd_pkg::HGT_W'(4096))
            h_eff = bbd_pkg::HGT_W'(4096);
    end

    assign inflight = {1'b0, qstat.count} + (bbd_pkg::QCNT_W+1)'(a_valid_reg & a_emit_reg);
    assign pix_in.ready = inflight < (bbd_pkg::QCNT_W+1)'(bbd_pkg::QDEPTH);
    assign accept = pix_in.valid & pix_in.ready;

    // classify the incoming sample
    always_comb
    begin
        r13 = {1'b0, row_reg};
        c12 = {1'b0, col_reg};
        y_even  = !row_reg[0] && (r13 >= bbd_pkg::HGT_W'(2)) && (r13 <= h_eff - bbd_pkg::HGT_W'(2));
        y_bot   = (r13 == h_eff - bbd_pkg::HGT_W'(1));
        x_even  = !col_reg[0] && (c12 >= bbd_pkg::WID_W'(2)) && (c12 <= w_eff - bbd_pkg::WID_W'(2));
        x_right = (c12 == w_eff - bbd_pkg::WID_W'(1));
        a_emit_next = (y_even || y_bot) && (x_even || x_right);
        a_y_next = y_even ? row_reg - bbd_pkg::ROW_W'(2)
                          : bbd_pkg::ROW_W'(h_eff - bbd_pkg::HGT_W'(2));
        a_x_next = x_even ? col_reg - bbd_pkg::COL_W'(2)
                          : bbd_pkg::COL_W'(w_eff - bbd_pkg::WID_W'(2));
        if (x_even)
            a_cmode_next = (col_reg == bbd_pkg::COL_W'(2)) ? bbd_pkg::CM_LEFT : bbd_pkg::CM_NORMAL;
        else if (x_right)
            a_cmode_next = bbd_pkg::CM_RIGHT;
        else
            a_cmode_next = bbd_pkg::CM_NORMAL;
        if (y_bot)
            a_rowk_next = {2'd1, 2'd0, 2'd1, 2'd2};
        else if (row_reg == bbd_pkg::ROW_W'(2))
            a_rowk_next = {2'd0, 2'd1, 2'd2, 2'd1};
        else
            a_rowk_next = {2'd0, 2'd1, 2'd2, 2'd3};
        if (c12 + bbd_pkg::WID_W'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = (r13 + bbd_pkg::HGT_W'(1) >= h_eff) ? '0 : row_reg + bbd_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + bbd_pkg::COL_W'(1);
            row_next = row_reg;
        end
    end

    for (genvar g = 0; g < bbd_pkg::LINES; g++)
    begin : g_bank
        logic [bbd_pkg::PIX_W-1:0] mem [bbd_pkg::MAX_WIDTH];
        logic [bbd_pkg::PIX_W-1:0] rd_reg;
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                if (row_reg[bbd_pkg::BANK_W-1:0] == bbd_pkg::BANK_W'(g))
                    mem[col_reg] <= pix_in.raw_pixel;
                rd_reg <= mem[col_reg];
            end
        end
        assign rd_data[g] = rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_emit_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                a_emit_reg <= a_emit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg   <= pix_in.raw_pixel;
            a_bank_reg  <= row_reg[bbd_pkg::BANK_W-1:0];
            a_rowk_reg  <= a_rowk_next;
            a_cmode_reg <= a_cmode_next;
            a_y_reg     <= a_y_next;
            a_x_reg     <= a_x_next;
        end
        if (a_valid_reg)
        begin
            s_reg[0] <= vec;
            s_reg[1] <= s_reg[0];
            s_reg[2] <= s_reg[1];
        end
    end

    // column of the window for the sample held in stage A
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (a_rowk_reg[i] == 2'd0)
                vec[i] = a_pix_reg;
            else
                vec[i] = rd_data[a_bank_reg - bbd_pkg::BANK_W'(a_rowk_reg[i])];
        end
        case (a_cmode_reg)
            bbd_pkg::CM_LEFT:
            begin
                cs[0] = s_reg[0];
                cs[1] = s_reg[1];
                cs[2] = s_reg[0];
                cs[3] = vec;
            end
            bbd_pkg::CM_RIGHT:
            begin
                cs[0] = s_reg[1];
                cs[1] = s_reg[0];
                cs[2] = vec;
                cs[3] = s_reg[0];
            end
            default:
            begin
                cs[0] = s_reg[2];
                cs[1] = s_reg[1];
                cs[2] = s_reg[0];
                cs[3] = vec;
            end
        endcase
        push.valid = a_valid_reg & a_emit_reg;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                push.entry.win[i][j] = cs[j][i];
        push.entry.y = a_y_reg;
        push.entry.x = a_x_reg;
    end

endmodule

FILE: hdl/bbd_queue.sv
// Block queue between front and back end.
module bbd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  bbd_pkg::push_t    push,
    input  logic              pop,
    output bbd_pkg::qstat_t   qstat,
    output bbd_pkg::qentry_t  head
);

    bbd_pkg::qentry_t            q_reg [bbd_pkg::QDEPTH];
    logic [bbd_pkg::QPTR_W-1:0]  wr_reg, rd_reg;
    logic [bbd_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
            cnt_next = cnt_reg + bbd_pkg::QCNT_W'(1);
        else if (!push.valid && pop)
            cnt_next = cnt_reg - bbd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
                wr_reg <= wr_reg + bbd_pkg::QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + bbd_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            q_reg[wr_reg] <= push.entry;
    end

    assign head           = q_reg[rd_reg];
    assign qstat.count    = cnt_reg;
    assign qstat.nonempty = (cnt_reg != '0);

endmodule

FILE: hdl/bbd_back.sv
// Back end: interpolates the four pixels of each queued block into the output register.
module bbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pattern,
    input  bbd_pkg::qstat_t   qstat,
    input  bbd_pkg::qentry_t  head,
    output logic              pop,
    bbd_rgb_if.source         rgb_out
);

    logic [1:0]                 phase_reg;
    logic                       valid_reg;
    logic [bbd_pkg::PIX_W-1:0]  red_reg, green_reg, blue_reg;
    logic [bbd_pkg::ROW_W-1:0]  row_reg;
    logic [bbd_pkg::COL_W-1:0]  col_reg;
    logic                       last_reg;
    logic [bbd_pkg::PIX_W-1:0]  red_next, green_next, blue_next;
    logic                       load;
    bbd_pkg::window_t           p;

    function automatic logic [bbd_pkg::PIX_W-1:0] avg2(input logic [bbd_pkg::PIX_W-1:0] a,
                                                       input logic [bbd_pkg::PIX_W-1:0] b);
        logic [bbd_pkg::PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[bbd_pkg::PIX_W:1];
    endfunction

    function automatic logic [bbd_pkg::PIX_W-1:0] avg4(input logic [bbd_pkg::PIX_W-1:0] a,
                                                       input logic [bbd_pkg::PIX_W-1:0] b,
                                                       input logic [bbd_pkg::PIX_W-1:0] c,
                                                       input logic [bbd_pkg::PIX_W-1:0] d);
        logic [bbd_pkg::PIX_W+1:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
        return s[bbd_pkg::PIX_W+1:2];
    endfunction

    assign p    = head.win;
    assign load = qstat.nonempty && (!valid_reg || rgb_out.ready);
    assign pop  = load && (phase_reg == 2'd3);

    always_comb
    begin
        case ({pattern, phase_reg})
            3'b000:
            begin
                red_next   = p[1][1];
                green_next = avg4(p[0][1], p[1][0], p[1][2], p[2][1]);
                blue_next  = avg4(p[0][0], p[0][2], p[2][0], p[2][2]);
            end
            3'b001:
            begin
                red_next   = avg2(p[1][1], p[1][3]);
                green_next = p[1][2];
                blue_next  = avg2(p[0][2], p[2][2]);
            end
            3'b010:
            begin
                red_next   = avg2(p[1][1], p[3][1]);
                green_next = p[2][1];
                blue_next  = avg2(p[2][0], p[2][2]);
            end
            3'b011:
            begin
                red_next   = avg4(p[1][1], p[1][3], p[3][1], p[3][3]);
                green_next = avg4(p[1][2], p[2][1], p[2][3], p[3][2]);
                blue_next  = p[2][2];
            end
            3'b100:
            begin
                red_next   = avg2(p[0][1], p[2][1]);
                green_next = p[1][1];
                blue_next  = avg2(p[1][0], p[1][2]);
            end
            3'b101:
            begin
                red_next   = avg4(p[0][1], p[0][3], p[2][1], p[2][3]);
                green_next = avg4(p[0][2], p[1][1], p[2][2], p[1][3]);
                blue_next  = p[1][2];
            end
            3'b110:
            begin
                red_next   = p[2][1];
                green_next = avg4(p[2][0], p[1][1], p[2][2], p[3][1]);
                blue_next  = avg4(p[1][0], p[1][2], p[3][0], p[3][2]);
            end
            default:
            begin
                red_next   = avg2(p[2][1], p[2][3]);
                green_next = p[2][2];
                blue_next  = avg2(p[1][2], p[3][2]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg <= phase_reg + 2'd1;
                valid_reg <= 1'b1;
            end
            else if (rgb_out.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            row_reg   <= head.y + bbd_pkg::ROW_W'(phase_reg[1]);
            col_reg   <= head.x + bbd_pkg::COL_W'(phase_reg[0]);
            last_reg  <= (phase_reg == 2'd3);
        end
    end

    assign rgb_out.valid      = valid_reg;
    assign rgb_out.red        = red_reg;
    assign rgb_out.green      = green_reg;
    assign rgb_out.blue       = blue_reg;
    assign rgb_out.pixel_row  = row_reg;
    assign rgb_out.pixel_col  = col_reg;
    assign rgb_out.block_last = last_reg;

endmodule

FILE: hdl/bbd_checker.sv
// Port-level checker for the Bayer demosaic and its bind.
`include "bayer_bilinear_demosaic_defines.svh"

module bbd_port_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [bbd_pkg::PIX_W-1:0] red,
    input logic [bbd_pkg::ROW_W-1:0] pixel_row,
    input logic [bbd_pkg::COL_W-1:0] pixel_col,
    input logic                      block_last
);

    `BBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(red) && $stable(pixel_col))
    `BBD_ASSERT_NOW(a_last_pos, clk, rst_n, out_valid && block_last,
                    pixel_row[0] && pixel_col[0])
    `BBD_ASSERT_NOW(a_top_right, clk, rst_n, out_valid && !block_last && pixel_col[0],
                    !pixel_row[0])

endmodule

bind bayer_bilinear_demosaic bbd_port_checker u_bbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (rgb_out.valid),
    .out_ready  (rgb_out.ready),
    .red        (rgb_out.red),
    .pixel_row  (rgb_out.pixel_row),
    .pixel_col  (rgb_out.pixel_col),
    .block_last (rgb_out.block_last)
);

FILE: tb/bbd_checker.sv
// Scoreboard for the Bayer demosaic: mirrors the line stores and checks every RGB word.
module bbd_checker
    import bbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    input  logic                pix_ready,
    input  logic [PIX_W-1:0]    raw_pixel,
    input  logic                rgb_valid,
    input  logic                rgb_ready,
    input  logic [PIX_W-1:0]    red,
    input  logic [PIX_W-1:0]    green,
    input  logic [PIX_W-1:0]    blue,
    input  logic [ROW_W-1:0]    pixel_row,
    input  logic [COL_W-1:0]    pixel_col,
    input  logic                block_last,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]   cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  checked
);

    typedef struct {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } rgb_px_t;

    logic [PIX_W-1:0] line_mem [0:LINES*MAX_WIDTH-1];
    rgb_px_t          rgb_q [$];
    int               col_cnt;
    int               row_cnt;
    logic             bayer_gbrg;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;

    assign pending = rgb_q.size();

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, want %0d", $realtime, field, got, want);
        errors++;
    endtask

    function automatic int sample_at(input int row, input int col, input int w, input int h);
        if (row < 0) row += 2;
        if (row >= h) row -= 2;
        if (col < 0) col += 2;
        if (col >= w) col -= 2;
        return line_mem[(row % LINES) * MAX_WIDTH + col];
    endfunction

    task automatic push_px(input int r, input int g, input int b, input int row,
                           input int col, input logic last);
        rgb_px_t px;
        px.r = PIX_W'(r);
        px.g = PIX_W'(g);
        px.b = PIX_W'(b);
        px.row = ROW_W'(row);
        px.col = COL_W'(col);
        px.last = last;
        rgb_q.push_back(px);
    endtask

    task automatic demosaic_sample(input logic [PIX_W-1:0] v);
        int w, h, r, c, y, x;
        int p [4][4];
        w = int'(width_reg & 12'hFFE);
        if (w < 4) w = 4;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(height_reg & 13'h1FFE);
        if (h < 4) h = 4;
        if (h > 4096) h = 4096;
        r = row_cnt;
        c = col_cnt;
        y = -1;
        x = -1;
        if (c < MAX_WIDTH) line_mem[(r % LINES) * MAX_WIDTH + c] = v;
        if (r % 2 == 0 && r >= 2 && r <= h - 2) y = r - 2;
        else if (r == h - 1) y = h - 2;
        if (c % 2 == 0 && c >= 2 && c <= w - 2) x = c - 2;
        else if (c == w - 1) x = w - 2;
        if (y >= 0 && x >= 0) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    p[i][j] = sample_at(y - 1 + i, x - 1 + j, w, h);
            if (!bayer_gbrg) begin
                push_px(p[1][1], (p[0][1] + p[1][0] + p[1][2] + p[2][1]) / 4,
                        (p[0][0] + p[0][2] + p[2][0] + p[2][2]) / 4, y, x, 1'b0);
                push_px((p[1][1] + p[1][3]) / 2, p[1][2], (p[0][2] + p[2][2]) / 2,
                        y, x + 1, 1'b0);
                push_px((p[1][1] + p[3][1]) / 2, p[2][1], (p[2][0] + p[2][2]) / 2,
                        y + 1, x, 1'b0);
                push_px((p[1][1] + p[1][3] + p[3][1] + p[3][3]) / 4,
                        (p[1][2] + p[2][1] + p[2][3] + p[3][2]) / 4, p[2][2],
                        y + 1, x + 1, 1'b1);
            end
            else begin
                push_px((p[0][1] + p[2][1]) / 2, p[1][1], (p[1][0] + p[1][2]) / 2,
                        y, x, 1'b0);
                push_px((p[0][1] + p[0][3] + p[2][1] + p[2][3]) / 4,
                        (p[0][2] + p[1][1] + p[2][2] + p[1][3]) / 4, p[1][2],
                        y, x + 1, 1'b0);
                push_px(p[2][1], (p[2][0] + p[1][1] + p[2][2] + p[3][1]) / 4,
                        (p[1][0] + p[1][2] + p[3][0] + p[3][2]) / 4, y + 1, x, 1'b0);
                push_px((p[2][1] + p[2][3]) / 2, p[2][2], (p[1][2] + p[3][2]) / 2,
                        y + 1, x + 1, 1'b1);
            end
        end
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else begin
            col_cnt = c + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_cnt    = 0;
            row_cnt    = 0;
            bayer_gbrg = 1'b0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
            checked    = 0;
            rgb_q.delete();
        end
        else begin
            if (rgb_valid && rgb_ready) begin
                if (rgb_q.size() == 0) begin
                    $display("%0t: unexpected RGB word at row %0d col %0d",
                             $realtime, pixel_row, pixel_col);
                    errors++;
                end
                else begin
                    rgb_px_t want;
                    want = rgb_q.pop_front();
                    checked++;
                    if (red !== want.r) report_mismatch("red", red, want.r);
                    if (green !== want.g) report_mismatch("green", green, want.g);
                    if (blue !== want.b) report_mismatch("blue", blue, want.b);
                    if (pixel_row !== want.row) report_mismatch("pixel_row", pixel_row, want.row);
                    if (pixel_col !== want.col) report_mismatch("pixel_col", pixel_col, want.col);
                    if (block_last !== want.last)
                        report_mismatch("block_last", block_last, want.last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PATTERN: bayer_gbrg = cfg_data[0];
                    CFG_WIDTH:   width_reg  = cfg_data[WID_W-1:0];
                    CFG_HEIGHT:  height_reg = cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            if (pix_valid && pix_ready) demosaic_sample(raw_pixel);
        end
    end

endmodule

FILE: tb/tb_bayer_bilinear_demosaic.sv
// Top of the Bayer demosaic testbench: clock, reset, stimulus and verdict.
module tb_bayer_bilinear_demosaic;
    import bbd_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   checked;
    int   idle_cycles;
    int   samples_sent;
    int   frames_sent;
    int   random_samples;
    bit   no_gaps;

    bbd_pixel_if pix_in ();
    bbd_rgb_if   rgb_out ();
    bbd_cfg_if   cfg ();

    bayer_bilinear_demosaic DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .rgb_out (rgb_out.source),
        .cfg     (cfg.sink)
    );

    bbd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_in.valid),
        .pix_ready  (pix_in.ready),
        .raw_pixel  (pix_in.raw_pixel),
        .rgb_valid  (rgb_out.valid),
        .rgb_ready  (rgb_out.ready),
        .red        (rgb_out.red),
        .green      (rgb_out.green),
        .blue       (rgb_out.blue),
        .pixel_row  (rgb_out.pixel_row),
        .pixel_col  (rgb_out.pixel_col),
        .block_last (rgb_out.block_last),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PIX_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= DATA_W'(value);
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [PIX_W-1:0] v);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid     <= 1'b1;
        pix_in.raw_pixel <= v;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mode 0: random, 1: checkerboard extremes, 2: all ones, 3: ramp
    task automatic send_frame(input int w, input int h, input int mode);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                case (mode)
                    1: send_sample(((r + c) % 2) ? '1 : '0);
                    2: send_sample('1);
                    3: send_sample(PIX_W'(r * 37 + c * 11));
                    default: send_sample(pick_sample());
                endcase
        frames_sent++;
        drain();
    endtask

    task automatic set_frame(input int pat, input int wreg, input int hreg);
        write_reg(CFG_PATTERN, pat);
        write_reg(CFG_WIDTH, wreg);
        write_reg(CFG_HEIGHT, hreg);
    endtask

    initial
    begin
        rgb_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            rgb_out.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                rgb_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_in.valid && pix_in.ready) || (rgb_out.valid && rgb_out.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a word", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int w, h;
        pix_in.valid     = 1'b0;
        pix_in.raw_pixel = '0;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_PATTERN;
        cfg.data         = '0;
        idle_cycles      = 0;
        samples_sent     = 0;
        frames_sent      = 0;
        no_gaps          = 1'b0;
        rst_n            = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame(0, 4, 4);
        send_frame(4, 4, 1);
        set_frame(1, 7, 5);
        send_frame(6, 4, 3);
        set_frame(0, 2, 0);
        send_frame(4, 4, 2);

        random_samples = 0;
        while (random_samples < 150) begin
            w = 2 * $urandom_range(2, 5);
            h = 2 * $urandom_range(2, 4);
            no_gaps = ($urandom_range(0, 3) == 0);
            set_frame($urandom_range(0, 1), w | $urandom_range(0, 1), h | $urandom_range(0, 1));
            send_frame(w, h, 0);
            random_samples += w * h;
        end
        no_gaps = 1'b0;

        $display("Sent %0d samples in %0d frames, checked %0d RGB words", samples_sent,
                 frames_sent, checked);
        $display("Covered both Bayer layouts, odd and undersized frame sizes and random stalls");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
